@@ sv/emin_pkg.sv @@
// Shared types, constants and helpers of the grayscale erosion filter.
package emin_pkg;

	localparam int LINE_DEPTH = 1024;
	localparam int COL_W      = 10;
	localparam int ROW_W      = 12;
	localparam int PIX_W      = 16;
	localparam int WIN_MAX    = 15;
	localparam int WIN_W      = 4;
	localparam int HMIN_N     = 16;
	localparam int BANKS      = 32;
	localparam int BANK_W     = 5;
	localparam int QDEPTH     = 4;
	localparam int QPTR_W     = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 13;
	localparam int OUT_DATA_W = 40;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_IMAGE_WIDTH   = 3'd0,
		CFG_IMAGE_HEIGHT  = 3'd1,
		CFG_AREA_LEFT     = 3'd2,
		CFG_AREA_RIGHT    = 3'd3,
		CFG_AREA_TOP      = 3'd4,
		CFG_AREA_BOTTOM   = 3'd5,
		CFG_WINDOW_WIDTH  = 3'd6,
		CFG_WINDOW_HEIGHT = 3'd7
	} cfg_idx_t;

	localparam logic ACT_PIXEL = 1'b0;
	localparam logic ACT_FLUSH = 1'b1;

	// clamped geometry seen by front and back
	typedef struct packed {
		logic [COL_W-1:0] w_m1;
		logic [ROW_W-1:0] h_m1;
		logic [WIN_W-1:0] ww;
		logic [WIN_W-1:0] ax;
		logic [WIN_W-1:0] bx;
		logic [WIN_W-1:0] ay;
		logic [WIN_W-1:0] by;
		logic [ROW_W-1:0] left;
		logic [ROW_W-1:0] right;
		logic [ROW_W-1:0] top;
		logic [ROW_W-1:0] bottom;
	} geom_t;

	// one classified item: an optional store write and an optional result job
	typedef struct packed {
		logic              wr;
		logic [PIX_W-1:0]  pix;
		logic [COL_W-1:0]  wcol;
		logic [BANK_W-1:0] wbank;
		logic              job;
		logic [ROW_W-1:0]  r;
		logic [COL_W-1:0]  c;
		logic              last;
	} entry_t;

	// column stream control from the column walker to the row stage
	typedef struct packed {
		logic             sh;
		logic             shv;
		logic             clr;
		logic             emit;
		logic             last;
		logic             proc;
		logic [COL_W-1:0] c;
		logic [ROW_W-1:0] r;
	} col_ctrl_t;

	function automatic logic [PIX_W-1:0] pmin(input logic [PIX_W-1:0] a,
		input logic [PIX_W-1:0] b);
		return (a < b) ? a : b;
	endfunction

endpackage

@@ sv/emin_front.sv @@
// Front end: accepts items, tracks input and result positions, classifies items.
module emin_front import emin_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  geom_t            geom,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [PIX_W-1:0] s_tdata,
	input  logic             s_tuser,
	input  logic             q_full,
	output logic             q_push,
	output entry_t           q_entry
);

	logic [COL_W-1:0] in_col_q, out_col_q, ic, oc, nc;
	logic [ROW_W-1:0] in_row_q, out_row_q, ir, orr, nr;
	logic             drain_q, dr, is_pix, active, ahead, job, last, acc;
	logic [ROW_W:0]   nr_sum;
	logic [COL_W:0]   nc_sum;

	assign s_tready = !q_full;
	assign acc      = s_tvalid && s_tready;

	always_comb begin
		ic = in_col_q;
		ir = in_row_q;
		oc = out_col_q;
		orr = out_row_q;
		dr = drain_q;
		is_pix = (s_tuser == ACT_PIXEL);
		// a pixel while draining opens a new image
		if (is_pix && drain_q) begin
			ic = '0;
			ir = '0;
			oc = '0;
			orr = '0;
			dr = 1'b0;
		end
		q_entry.wr = is_pix;
		q_entry.pix = s_tdata;
		q_entry.wcol = ic;
		q_entry.wbank = ir[BANK_W-1:0];
		if (is_pix) begin
			if (ic == geom.w_m1) begin
				ic = '0;
				if (ir == geom.h_m1) begin
					ir = '0;
					dr = 1'b1;
				end else begin
					ir = ir + 1'b1;
				end
			end else begin
				ic = ic + 1'b1;
			end
		end
		active = is_pix || drain_q;
		nr_sum = {1'b0, orr} + (ROW_W+1)'(geom.ay);
		nc_sum = {1'b0, oc} + (COL_W+1)'(geom.ax);
		nr = (nr_sum > {1'b0, geom.h_m1}) ? geom.h_m1 : nr_sum[ROW_W-1:0];
		nc = (nc_sum > {1'b0, geom.w_m1}) ? geom.w_m1 : nc_sum[COL_W-1:0];
		// last neighbor of the next result already in
		ahead = (nr < ir) || ((nr == ir) && (nc < ic));
		job = active && (dr || ahead);
		q_entry.job = job;
		q_entry.r = orr;
		q_entry.c = oc;
		last = 1'b0;
		if (job) begin
			if (oc == geom.w_m1) begin
				oc = '0;
				if (orr == geom.h_m1) begin
					orr = '0;
					last = 1'b1;
					if (dr) begin
						dr = 1'b0;
						ic = '0;
						ir = '0;
					end
				end else begin
					orr = orr + 1'b1;
				end
			end else begin
				oc = oc + 1'b1;
			end
		end
		q_entry.last = last;
	end

	assign q_push = acc && (is_pix || job);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q <= '0;
			in_row_q <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			drain_q <= 1'b0;
		end else if (acc) begin
			in_col_q <= ic;
			in_row_q <= ir;
			out_col_q <= oc;
			out_row_q <= orr;
			drain_q <= dr;
		end
	end

endmodule

@@ sv/emin_queue.sv @@
// Short queue between the front end and the back end.
module emin_queue import emin_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	input  logic   pop,
	output entry_t head,
	output logic   full,
	output logic   empty
);

	entry_t            q_mem [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   cnt_q;

	assign full  = (cnt_q == (QPTR_W+1)'(QDEPTH));
	assign empty = (cnt_q == '0);
	assign head  = q_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

@@ sv/emin_col.sv @@
// Back end column walker: row-banked line store and vertical minimum per column.
module emin_col import emin_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  geom_t            geom,
	input  logic             adv,
	input  logic             q_empty,
	input  entry_t           q_head,
	output logic             q_pop,
	output col_ctrl_t        ctl_s3,
	output logic [PIX_W-1:0] vmin_s3,
	output logic [PIX_W-1:0] raw_s3
);

	typedef struct packed {
		logic [BANK_W-1:0] r0b;
		logic [WIN_W-1:0]  span;
		logic [BANK_W-1:0] rb;
	} vwin_t;

	logic             s0_valid_q;
	entry_t           s0_q;
	logic [WIN_W-1:0] pf_q;
	logic             col0, s0_done, in_range, we;
	logic [COL_W:0]   addr;
	logic [COL_W-1:0] raddr;
	logic [ROW_W-1:0] r0, r1;
	logic [ROW_W:0]   r1_sum;
	logic [ROW_W-1:0] c_ext;
	col_ctrl_t        ctl_d, ctl_s1, ctl_s2;
	vwin_t            win_d, win_s1;

	wire [BANKS-1:0][PIX_W-1:0] bank_rd;

	logic [BANK_W-1:0] off [BANKS];
	logic [PIX_W-1:0]  lv0 [BANKS];
	logic [PIX_W-1:0]  lv1 [BANKS/2];
	logic [PIX_W-1:0]  lv2 [BANKS/4];
	logic [PIX_W-1:0]  min8_s2 [BANKS/4];
	logic [PIX_W-1:0]  lv3 [BANKS/8];
	logic [PIX_W-1:0]  lv4 [BANKS/16];
	logic [PIX_W-1:0]  raw_s2;

	// a row-start job reads columns 0..ax, one per cycle while adv is high
	assign col0    = s0_q.job && (s0_q.c == '0);
	assign s0_done = !s0_valid_q || !s0_q.job || !col0 || (pf_q == geom.ax);
	assign q_pop   = adv && s0_done && !q_empty;
	assign we      = q_pop && q_head.wr;

	always_comb begin
		addr = col0 ? (COL_W+1)'(pf_q) : ({1'b0, s0_q.c} + (COL_W+1)'(geom.ax));
		in_range = (addr <= {1'b0, geom.w_m1});
		raddr = addr[COL_W-1:0];
		r0 = (s0_q.r > ROW_W'(geom.by)) ? (s0_q.r - ROW_W'(geom.by)) : '0;
		r1_sum = {1'b0, s0_q.r} + (ROW_W+1)'(geom.ay);
		r1 = (r1_sum > {1'b0, geom.h_m1}) ? geom.h_m1 : r1_sum[ROW_W-1:0];
		win_d.r0b = r0[BANK_W-1:0];
		win_d.span = WIN_W'(r1 - r0);
		win_d.rb = s0_q.r[BANK_W-1:0];
		c_ext = ROW_W'(s0_q.c);
		ctl_d.sh = s0_valid_q && s0_q.job;
		ctl_d.shv = in_range;
		ctl_d.clr = col0 && (pf_q == '0);
		ctl_d.emit = s0_valid_q && s0_q.job && s0_done;
		ctl_d.last = s0_q.last;
		ctl_d.proc = !((c_ext < geom.left) || (c_ext > geom.right) ||
			(s0_q.r < geom.top) || (s0_q.r > geom.bottom));
		ctl_d.c = s0_q.c;
		ctl_d.r = s0_q.r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s0_valid_q <= 1'b0;
			pf_q <= '0;
		end else if (adv) begin
			if (q_pop) begin
				s0_valid_q <= 1'b1;
				pf_q <= '0;
			end else if (s0_done) begin
				s0_valid_q <= 1'b0;
			end else begin
				pf_q <= pf_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			s0_q <= q_head;
		end
	end

	// one bank per row modulo 32; write before read in item order
	for (genvar b = 0; b < BANKS; b++) begin : g_bank
		logic [PIX_W-1:0] mem [LINE_DEPTH];
		logic [PIX_W-1:0] rd_s1;
		always_ff @(posedge clk) begin
			if (adv) begin
				if (we && (q_head.wbank == BANK_W'(b))) begin
					mem[q_head.wcol] <= q_head.pix;
				end
				rd_s1 <= mem[raddr];
			end
		end
		assign bank_rd[b] = rd_s1;
	end

	// mask rows outside the window, first two min levels
	always_comb begin
		for (int b = 0; b < BANKS; b++) begin
			off[b] = BANK_W'(b) - win_s1.r0b;
			lv0[b] = (off[b] <= {1'b0, win_s1.span}) ? bank_rd[b] : '1;
		end
		for (int i = 0; i < BANKS/2; i++) begin
			lv1[i] = pmin(lv0[2*i], lv0[2*i+1]);
		end
		for (int i = 0; i < BANKS/4; i++) begin
			lv2[i] = pmin(lv1[2*i], lv1[2*i+1]);
		end
	end

	always_comb begin
		for (int i = 0; i < BANKS/8; i++) begin
			lv3[i] = pmin(min8_s2[2*i], min8_s2[2*i+1]);
		end
		for (int i = 0; i < BANKS/16; i++) begin
			lv4[i] = pmin(lv3[2*i], lv3[2*i+1]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else if (adv) begin
			ctl_s1 <= s0_valid_q ? ctl_d : '0;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			win_s1 <= win_d;
			min8_s2 <= lv2;
			raw_s2 <= bank_rd[win_s1.rb];
			vmin_s3 <= pmin(lv4[0], lv4[1]);
			raw_s3 <= raw_s2;
		end
	end

endmodule

@@ sv/emin_row.sv @@
// Back end row stage: column line, horizontal minimum and output register.
module emin_row import emin_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  geom_t                 geom,
	input  col_ctrl_t             ctl_s3,
	input  logic [PIX_W-1:0]      vmin_s3,
	input  logic [PIX_W-1:0]      raw_s3,
	output logic                  adv,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic                  m_tlast
);

	logic [PIX_W-1:0]   vline_q [WIN_MAX];
	logic [PIX_W-1:0]   rline_q [WIN_MAX];
	logic [WIN_MAX-1:0] vld_q;
	col_ctrl_t          ctl_s4, ctl_s5;
	logic [PIX_W-1:0]   hv [HMIN_N];
	logic [PIX_W-1:0]   h1 [HMIN_N/2];
	logic [PIX_W-1:0]   h2 [HMIN_N/4];
	logic [PIX_W-1:0]   min4_s5 [HMIN_N/4];
	logic [PIX_W-1:0]   center_s5;
	logic [PIX_W-1:0]   h3 [HMIN_N/8];
	logic [PIX_W-1:0]   res;

	assign adv = !m_tvalid || m_tready;

	// entry k holds column c+ax-k of the current result row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv && ctl_s3.sh) begin
			vld_q <= ctl_s3.clr ? {{(WIN_MAX-1){1'b0}}, ctl_s3.shv}
				: {vld_q[WIN_MAX-2:0], ctl_s3.shv};
		end
	end

	always_ff @(posedge clk) begin
		if (adv && ctl_s3.sh) begin
			vline_q[0] <= vmin_s3;
			rline_q[0] <= raw_s3;
			for (int k = 1; k < WIN_MAX; k++) begin
				vline_q[k] <= vline_q[k-1];
				rline_q[k] <= rline_q[k-1];
			end
		end
	end

	always_comb begin
		for (int k = 0; k < WIN_MAX; k++) begin
			hv[k] = (vld_q[k] && (WIN_W'(k) < geom.ww)) ? vline_q[k] : '1;
		end
		hv[HMIN_N-1] = '1;
		for (int i = 0; i < HMIN_N/2; i++) begin
			h1[i] = pmin(hv[2*i], hv[2*i+1]);
		end
		for (int i = 0; i < HMIN_N/4; i++) begin
			h2[i] = pmin(h1[2*i], h1[2*i+1]);
		end
	end

	always_comb begin
		for (int i = 0; i < HMIN_N/8; i++) begin
			h3[i] = pmin(min4_s5[2*i], min4_s5[2*i+1]);
		end
		res = ctl_s5.proc ? pmin(h3[0], h3[1]) : center_s5;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s4 <= '0;
			ctl_s5 <= '0;
			m_tvalid <= 1'b0;
		end else if (adv) begin
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
			m_tvalid <= ctl_s5.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			min4_s5 <= h2;
			center_s5 <= rline_q[geom.ax];
			m_tdata <= {(OUT_DATA_W-PIX_W-COL_W-ROW_W)'(0), ctl_s5.r, ctl_s5.c, res};
			m_tlast <= ctl_s5.last;
		end
	end

endmodule

@@ sv/grayscale_erosion_min_filter_top.sv @@
// Top level of the streaming grayscale erosion (rectangular minimum) filter.
//
// Usage:
//  - s_* channel takes one item per handshake: a source pixel in raster order
//    (s_tuser low) or a flush tick (s_tuser high) that drains pending results
//    once the whole image is in. A pixel while draining starts a new image.
//  - m_* channel returns result pixels in raster order with their column and
//    row; m_tlast marks the final pixel of the image.
//  - cfg_* channel writes one geometry register per handshake; write only
//    while no item is in flight.
// Throughput: one item per cycle while the queue has room. The column walker
//  reads one column of all 32 row banks per cycle while the back end advances,
//  and the first result of each row first reads columns 0..ax, ax = (window_width-1)/2.
// Path: an item that completes a window reaches its result through the queue,
//  walker, bank read, two min-tree stages, line and two stages.
// Reset: counters clear, registers take their defaults; the line store has no
//  clearing pass and holds nothing valid until written.
// Stall: while a result is offered and m_tready is low the back end holds; the
//  front keeps accepting until the four-entry queue fills, then drops s_tready.
module grayscale_erosion_min_filter_top import emin_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [PIX_W-1:0]      s_tdata,   // [15:0] pixel_in
	input  logic                  s_tuser,   // [0] action (0 pixel, 1 flush)
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // [15:0] pixel_out, [25:16] out_column,
	                                         // [37:26] out_row, [39:38] zero
	output logic                  m_tlast,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [10:0] img_w_q;
	logic [12:0] img_h_q;
	logic [11:0] left_q, right_q, top_q, bottom_q;
	logic [3:0]  win_w_q, win_h_q;
	logic [3:0]  ww, wh;
	geom_t       geom;

	logic      q_push, q_pop, q_full, q_empty, adv;
	entry_t    q_entry, q_head;
	col_ctrl_t ctl_s3;
	logic [PIX_W-1:0] vmin_s3, raw_s3;

	assign cfg_ready = 1'b1;

	// register file, always ready
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_w_q <= 11'd640;
			img_h_q <= 13'd480;
			left_q <= 12'd0;
			right_q <= 12'd4095;
			top_q <= 12'd0;
			bottom_q <= 12'd4095;
			win_w_q <= 4'd3;
			win_h_q <= 4'd3;
		end else if (cfg_valid) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_IMAGE_WIDTH:   img_w_q <= cfg_data[10:0];
				CFG_IMAGE_HEIGHT:  img_h_q <= cfg_data;
				CFG_AREA_LEFT:     left_q <= cfg_data[11:0];
				CFG_AREA_RIGHT:    right_q <= cfg_data[11:0];
				CFG_AREA_TOP:      top_q <= cfg_data[11:0];
				CFG_AREA_BOTTOM:   bottom_q <= cfg_data[11:0];
				CFG_WINDOW_WIDTH:  win_w_q <= cfg_data[3:0];
				CFG_WINDOW_HEIGHT: win_h_q <= cfg_data[3:0];
				default:           win_h_q <= win_h_q;
			endcase
		end
	end

	// clamp geometry: zero sizes become one, oversize sizes the maximum
	always_comb begin
		ww = (win_w_q == '0) ? 4'd1 : win_w_q;
		wh = (win_h_q == '0) ? 4'd1 : win_h_q;
		if (img_w_q == '0) begin
			geom.w_m1 = '0;
		end else if (img_w_q > 11'(LINE_DEPTH)) begin
			geom.w_m1 = COL_W'(LINE_DEPTH - 1);
		end else begin
			geom.w_m1 = COL_W'(img_w_q - 1'b1);
		end
		if (img_h_q == '0) begin
			geom.h_m1 = '0;
		end else if (img_h_q > 13'd4096) begin
			geom.h_m1 = '1;
		end else begin
			geom.h_m1 = ROW_W'(img_h_q - 1'b1);
		end
		geom.ww = ww;
		geom.bx = ww >> 1;
		geom.ax = (ww - 1'b1) >> 1;
		geom.by = wh >> 1;
		geom.ay = (wh - 1'b1) >> 1;
		geom.left = left_q;
		geom.top = top_q;
		geom.right = (right_q < ROW_W'(geom.w_m1)) ? right_q : ROW_W'(geom.w_m1);
		geom.bottom = (bottom_q < geom.h_m1) ? bottom_q : geom.h_m1;
	end

	emin_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.geom     (geom),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_entry  (q_entry)
	);

	emin_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_entry),
		.pop        (q_pop),
		.head       (q_head),
		.full       (q_full),
		.empty      (q_empty)
	);

	emin_col u_col (
		.clk     (clk),
		.arst_n  (arst_n),
		.geom    (geom),
		.adv     (adv),
		.q_empty (q_empty),
		.q_head  (q_head),
		.q_pop   (q_pop),
		.ctl_s3  (ctl_s3),
		.vmin_s3 (vmin_s3),
		.raw_s3  (raw_s3)
	);

	emin_row u_row (
		.clk      (clk),
		.arst_n   (arst_n),
		.geom     (geom),
		.ctl_s3   (ctl_s3),
		.vmin_s3  (vmin_s3),
		.raw_s3   (raw_s3),
		.adv      (adv),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

@@ sv/emin_chk.sv @@
// Port checker of the erosion filter, bound to the top level.
module emin_chk import emin_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata,
	input logic                  m_tlast
);

	// held result stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	// no result out of reset
	a_rst: assert property (@(posedge clk) !arst_n |-> !m_tvalid)
		else $error("result offered during reset");

	// pad bits above the row field stay zero
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[OUT_DATA_W-1:PIX_W+COL_W+ROW_W] == '0)
		else $error("pad bits set");

endmodule

bind grayscale_erosion_min_filter_top emin_chk u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

@@ bench/testbench.sv @@
// Self-checking bench for the streaming grayscale erosion filter.
module testbench;
	import emin_pkg::*;

	localparam int STORE_ROWS = 30;
	localparam int STALL_LIMIT = 20000;

	typedef struct packed {
		logic [PIX_W-1:0] pix;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic             last;
	} eroded_px_t;

	// Tracks geometry, line store and raster counters; predicts each result pixel.
	class erosion_scoreboard;
		logic [PIX_W-1:0] rows_seen [0:STORE_ROWS*LINE_DEPTH-1];
		int geo [8];
		int in_col, in_row, out_col, out_row;
		bit draining;
		eroded_px_t pending_px [$];
		int errors, results, pixels, flushes;

		function new();
			geo = '{640, 480, 0, 4095, 0, 4095, 3, 3};
		endfunction

		function int clampv(int v, int lo, int hi);
			return (v < lo) ? lo : (v > hi) ? hi : v;
		endfunction

		function int img_w();
			return clampv(geo[CFG_IMAGE_WIDTH], 1, LINE_DEPTH);
		endfunction

		function int img_h();
			return clampv(geo[CFG_IMAGE_HEIGHT], 1, 4096);
		endfunction

		function void set_reg(cfg_idx_t idx, int val);
			int masks [8];
			masks = '{'h7FF, 'h1FFF, 'hFFF, 'hFFF, 'hFFF, 'hFFF, 'hF, 'hF};
			geo[idx] = val & masks[idx];
		endfunction

		function int slot(int r, int c);
			return (r % STORE_ROWS) * LINE_DEPTH + (c % LINE_DEPTH);
		endfunction

		function logic [PIX_W-1:0] window_min(int r, int c, int w, int h);
			int ww, wh, bx, ax, by, ay, right, bottom, r0, r1, c0, c1;
			logic [PIX_W-1:0] m;
			ww = clampv(geo[CFG_WINDOW_WIDTH], 1, WIN_MAX);
			wh = clampv(geo[CFG_WINDOW_HEIGHT], 1, WIN_MAX);
			bx = ww / 2; ax = ww - 1 - bx;
			by = wh / 2; ay = wh - 1 - by;
			right = (geo[CFG_AREA_RIGHT] < w - 1) ? geo[CFG_AREA_RIGHT] : w - 1;
			bottom = (geo[CFG_AREA_BOTTOM] < h - 1) ? geo[CFG_AREA_BOTTOM] : h - 1;
			m = rows_seen[slot(r, c)];
			if (c < geo[CFG_AREA_LEFT] || c > right || r < geo[CFG_AREA_TOP] || r > bottom)
				return m;
			r0 = (r > by) ? r - by : 0;
			r1 = (r + ay < h - 1) ? r + ay : h - 1;
			c0 = (c > bx) ? c - bx : 0;
			c1 = (c + ax < w - 1) ? c + ax : w - 1;
			for (int y = r0; y <= r1; y++)
				for (int x = c0; x <= c1; x++)
					if (rows_seen[slot(y, x)] < m)
						m = rows_seen[slot(y, x)];
			return m;
		endfunction

		// Record one accepted item and queue the result it releases, if any.
		function void note_item(logic act, logic [PIX_W-1:0] pix);
			int w, h, ax, ay, got, need_r, need_c, r, c;
			bit last;
			eroded_px_t e;
			w = img_w();
			h = img_h();
			ax = clampv(geo[CFG_WINDOW_WIDTH], 1, WIN_MAX);
			ax = ax - 1 - ax / 2;
			ay = clampv(geo[CFG_WINDOW_HEIGHT], 1, WIN_MAX);
			ay = ay - 1 - ay / 2;
			last = 0;
			if (act == ACT_PIXEL) begin
				pixels++;
				if (draining) begin
					// a new image drops what the old one still owed
					draining = 0;
					out_row = 0; out_col = 0; in_row = 0; in_col = 0;
				end
				rows_seen[slot(in_row, in_col)] = pix;
				in_col++;
				if (in_col >= w) begin
					in_col = 0;
					in_row++;
					if (in_row >= h) begin
						in_row = 0;
						draining = 1;
					end
				end
			end else begin
				flushes++;
				if (!draining)
					return;
			end
			got = draining ? w * h : in_row * w + in_col;
			r = out_row;
			c = out_col;
			need_r = (r + ay < h - 1) ? r + ay : h - 1;
			need_c = (c + ax < w - 1) ? c + ax : w - 1;
			if (!draining && need_r * w + need_c >= got)
				return;
			e.pix = window_min(r, c, w, h);
			out_col++;
			if (out_col >= w) begin
				out_col = 0;
				out_row++;
				if (out_row >= h) begin
					out_row = 0;
					last = 1;
					if (draining) begin
						draining = 0;
						in_row = 0; in_col = 0;
					end
				end
			end
			e.col = c[COL_W-1:0];
			e.row = r[ROW_W-1:0];
			e.last = last;
			pending_px.push_back(e);
		endfunction

		function void check_result(eroded_px_t got);
			eroded_px_t e;
			results++;
			if (pending_px.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual pix=%h col=%0d row=%0d last=%b",
					$time, got.pix, got.col, got.row, got.last);
				return;
			end
			e = pending_px.pop_front();
			if (got.pix !== e.pix || got.col !== e.col || got.row !== e.row ||
				got.last !== e.last) begin
				errors++;
				$display("%0t: mismatch, expected pix=%h col=%0d row=%0d last=%b, actual pix=%h col=%0d row=%0d last=%b",
					$time, e.pix, e.col, e.row, e.last, got.pix, got.col, got.row, got.last);
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [PIX_W-1:0]      s_tdata;
	logic                  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tlast;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	erosion_scoreboard sb = new();
	bit steady;
	int quiet_cycles;
	int phases;

	grayscale_erosion_min_filter_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Stall the result side at random unless a steady stretch is running.
	always @(negedge clk) begin
		m_tready <= steady || ($urandom_range(99) >= 36);
	end

	// Check every accepted result; count cycles without any handshake.
	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			sb.check_result({m_tdata[15:0], m_tdata[25:16], m_tdata[37:26], m_tlast});
		if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > STALL_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic write_reg(cfg_idx_t idx, int val);
		@(negedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val[CFG_DATA_W-1:0];
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, val);
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	task automatic set_geometry(int w, int h, int l, int r, int t, int b, int ww, int wh);
		write_reg(CFG_IMAGE_WIDTH, w);
		write_reg(CFG_IMAGE_HEIGHT, h);
		write_reg(CFG_AREA_LEFT, l);
		write_reg(CFG_AREA_RIGHT, r);
		write_reg(CFG_AREA_TOP, t);
		write_reg(CFG_AREA_BOTTOM, b);
		write_reg(CFG_WINDOW_WIDTH, ww);
		write_reg(CFG_WINDOW_HEIGHT, wh);
	endtask

	// Present one item; leave tvalid high on return, already at a falling edge.
	task automatic send_item(logic act, logic [PIX_W-1:0] pix);
		while (!steady && $urandom_range(99) < 36) begin
			s_tvalid <= 0;
			@(negedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= act;
		s_tdata <= pix;
		do @(posedge clk); while (!s_tready);
		sb.note_item(act, pix);
		@(negedge clk);
	endtask

	function automatic logic [PIX_W-1:0] pick_pixel();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return PIX_W'($urandom_range(65535));
		endcase
	endfunction

	// Stream one image; a cut image stops after at most one flush while draining.
	task automatic stream_image(bit cut);
		int n;
		n = sb.img_w() * sb.img_h();
		for (int i = 0; i < n; i++) begin
			send_item(ACT_PIXEL, pick_pixel());
			// a flush before the image is complete must do nothing
			if ($urandom_range(9) == 0 && i < n - 1)
				send_item(ACT_FLUSH, PIX_W'($urandom_range(65535)));
		end
		if (cut) begin
			if (sb.draining)
				send_item(ACT_FLUSH, pick_pixel());
		end else begin
			while (sb.draining)
				send_item(ACT_FLUSH, pick_pixel());
		end
	endtask

	// Drop tvalid at once, then let the block settle so the next write finds it idle.
	task automatic settle();
		s_tvalid <= 0;
		while (sb.pending_px.size() != 0)
			@(negedge clk);
		repeat (30) @(negedge clk);
	endtask

	task automatic run_phase(int images);
		for (int k = 0; k < images; k++)
			stream_image(k < images - 1 && $urandom_range(3) == 0);
		settle();
		phases++;
	endtask

	initial begin
		int start_px;
		arst_n = 0;
		s_tvalid = 0;
		s_tuser = 0;
		s_tdata = 0;
		m_tready = 0;
		cfg_valid = 0;
		cfg_index = CFG_IMAGE_WIDTH;
		cfg_data = 0;
		steady = 0;
		quiet_cycles = 0;
		phases = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed: small centered window, then a cut image restarted by a pixel.
		set_geometry(4, 3, 0, 4095, 0, 4095, 3, 3);
		run_phase(1);
		stream_image(1);
		stream_image(0);
		settle();
		// One pixel, one-pixel window; zero sizes clamp up to one.
		set_geometry(1, 1, 0, 0, 0, 0, 1, 1);
		run_phase(2);
		set_geometry(0, 0, 0, 4095, 0, 4095, 0, 0);
		run_phase(2);
		// Wide window on one row; area left past right passes through.
		set_geometry(9, 1, 4095, 0, 0, 4095, 15, 15);
		run_phase(1);
		// One column, tall window.
		set_geometry(1, 9, 0, 4095, 0, 4095, 2, 15);
		run_phase(1);
		// Even window off-center, area with high bits set.
		set_geometry(4, 2, 'hAAA, 'h555, 'h555, 'hAAA, 15, 2);
		run_phase(1);
		set_geometry(6, 3, 1, 1000, 1, 4095, 8, 4);
		run_phase(1);

		// A long stretch with no idling on either side.
		steady = 1;
		set_geometry(9, 8, 0, 4095, 0, 4095, 3, 3);
		run_phase(2);
		steady = 0;

		// Random geometries over small images.
		start_px = sb.pixels;
		while (sb.pixels - start_px < 200) begin
			set_geometry($urandom_range(1, 9), $urandom_range(1, 8),
				($urandom_range(4) == 0) ? $urandom_range(4095) : $urandom_range(5),
				($urandom_range(4) == 0) ? 4095 : $urandom_range(8),
				($urandom_range(4) == 0) ? $urandom_range(4095) : $urandom_range(5),
				($urandom_range(4) == 0) ? 4095 : $urandom_range(7),
				$urandom_range(15), $urandom_range(15));
			run_phase($urandom_range(1, 4));
		end
		settle();

		$display("Covered %0d geometry phases: %0d pixels and %0d flush items in, %0d results checked.",
			phases, sb.pixels, sb.flushes, sb.results);
		if (sb.pending_px.size() != 0)
			$display("%0t: %0d expected results never arrived", $time, sb.pending_px.size());
		if (sb.errors == 0 && sb.pending_px.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
